>>> src/bat_pkg.sv
`default_nettype none

package bat_pkg;

    // Command codes on the item channel
    localparam logic CMD_SLOT    = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    // Configuration register indexes
    localparam logic CFG_REGULAR_LIMIT = 1'b0;
    localparam logic CFG_HIGH_LIMIT    = 1'b1;

    localparam int CFG_IDX_W  = 1;
    localparam int LIMIT_W    = 16;
    localparam int COUNT_W    = 17;
    localparam int CENTER_W   = 10;
    localparam int TYPE_W     = 10;

    // Types at or above this code are metals
    localparam logic [TYPE_W-1:0] METAL_TYPE = 10'd300;

    typedef struct packed {
        logic restart;
        logic high;
    } t_job_ctl;

endpackage

`default_nettype wire

>>> src/bat_if.sv
`default_nettype none

interface bat_in_if #(
    parameter int ATOM_BITS = 10
);
    logic                 valid;
    logic                 ready;
    logic                 cmd;
    logic [9:0]           center_atom;
    logic [9:0]           atom_type;
    logic [ATOM_BITS-1:0] neighbor;
    logic                 is_coordination;
    logic                 last_slot;

    modport source (
        output valid, cmd, center_atom, atom_type, neighbor, is_coordination, last_slot,
        input  ready
    );
    modport sink (
        input  valid, cmd, center_atom, atom_type, neighbor, is_coordination, last_slot,
        output ready
    );
endinterface

interface bat_out_if #(
    parameter int ATOM_BITS = 10
);
    logic                 valid;
    logic                 ready;
    logic                 is_high_coord;
    logic [15:0]          entry_index;
    logic [ATOM_BITS-1:0] first_end;
    logic [9:0]           vertex;
    logic [ATOM_BITS-1:0] second_end;
    logic [ATOM_BITS-1:0] third_neighbor;
    logic                 overflow;
    logic                 last_of_atom;

    modport source (
        output valid, is_high_coord, entry_index, first_end, vertex, second_end,
               third_neighbor, overflow, last_of_atom,
        input  ready
    );
    modport sink (
        input  valid, is_high_coord, entry_index, first_end, vertex, second_end,
               third_neighbor, overflow, last_of_atom,
        output ready
    );
endinterface

`default_nettype wire

>>> src/bat_front.sv
`default_nettype none

module bat_front
    import bat_pkg::*;
#(
    parameter int SLOTS     = 8,
    parameter int ATOM_BITS = 10,
    localparam int CNT_W    = $clog2(SLOTS + 1)
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    bat_in_if.sink                          i_item,
    input  wire logic                       i_q_full,
    output logic                            o_push,
    output t_job_ctl                        o_job_ctl,
    output logic [CNT_W-1:0]                o_job_m,
    output logic [CENTER_W-1:0]             o_job_center,
    output logic [SLOTS*ATOM_BITS-1:0]      o_job_sel
);

    logic [ATOM_BITS-1:0] r_pos  [SLOTS];   // slots by position
    logic [ATOM_BITS-1:0] r_real [SLOTS];   // real neighbors, compacted
    logic [ATOM_BITS-1:0] n_pos  [SLOTS];
    logic [ATOM_BITS-1:0] n_real [SLOTS];
    logic [CNT_W-1:0]     r_slot_cnt;
    logic [CNT_W-1:0]     r_real_cnt;
    logic                 r_any_coord;
    logic [CNT_W-1:0]     n_real_cnt;
    logic                 n_any_coord;

    logic accept;
    logic restart;
    logic store;
    logic cur_real;
    logic positional;

    assign i_item.ready = !i_q_full;
    assign accept       = i_item.valid && i_item.ready;
    assign restart      = (i_item.cmd == CMD_RESTART);

    // Slots past the capacity are dropped
    assign store    = (32'(r_slot_cnt) < SLOTS);
    assign cur_real = store && (i_item.neighbor != '0) && !i_item.is_coordination;

    assign n_real_cnt  = r_real_cnt + CNT_W'(cur_real);
    assign n_any_coord = r_any_coord || (store && i_item.is_coordination);

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            n_pos[i]  = (store && r_slot_cnt == CNT_W'(i)) ? i_item.neighbor : r_pos[i];
            n_real[i] = (cur_real && r_real_cnt == CNT_W'(i)) ? i_item.neighbor : r_real[i];
        end
    end

    // 3..5 real neighbors with no coordination slot: take slots by position
    assign positional = (32'(n_real_cnt) >= 3) && (32'(n_real_cnt) <= 5) && !n_any_coord;

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            o_job_sel[i*ATOM_BITS +: ATOM_BITS] = positional ? n_pos[i] : n_real[i];
        end
    end

    assign o_job_ctl.restart = restart;
    assign o_job_ctl.high    = (i_item.atom_type >= METAL_TYPE) || (32'(n_real_cnt) >= 5);
    assign o_job_m           = n_real_cnt;
    assign o_job_center      = i_item.center_atom;
    assign o_push            = accept && (restart ||
                               (i_item.last_slot && 32'(n_real_cnt) >= 2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_cnt  <= '0;
            r_real_cnt  <= '0;
            r_any_coord <= 1'b0;
        end else if (accept) begin
            if (restart || i_item.last_slot) begin
                r_slot_cnt  <= '0;
                r_real_cnt  <= '0;
                r_any_coord <= 1'b0;
            end else begin
                r_slot_cnt  <= r_slot_cnt + CNT_W'(store);
                r_real_cnt  <= n_real_cnt;
                r_any_coord <= n_any_coord;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_pos[i]  <= n_pos[i];
                r_real[i] <= n_real[i];
            end
        end
    end

endmodule

`default_nettype wire

>>> src/bat_queue.sv
`default_nettype none

module bat_queue #(
    parameter int WIDTH   = 8,
    parameter int DEPTH   = 2,
    localparam int PTR_W  = $clog2(DEPTH),
    localparam int FILL_W = $clog2(DEPTH + 1)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic                  o_full,
    output logic                  o_valid,
    output logic [WIDTH-1:0]      o_data
);

    logic [WIDTH-1:0]  r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [FILL_W-1:0] r_fill;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (32'(r_fill) == DEPTH);
    assign o_valid = (r_fill != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (32'(r_wr) == DEPTH - 1) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (32'(r_rd) == DEPTH - 1) ? '0 : r_rd + PTR_W'(1);
            end
            r_fill <= r_fill + FILL_W'(do_push) - FILL_W'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

>>> src/bat_back.sv
`default_nettype none

module bat_back
    import bat_pkg::*;
#(
    parameter int SLOTS     = 8,
    parameter int ATOM_BITS = 10,
    localparam int CNT_W    = $clog2(SLOTS + 1)
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire logic [LIMIT_W-1:0]          i_cfg_data,
    input  wire logic                        i_job_valid,
    input  wire t_job_ctl                    i_job_ctl,
    input  wire logic [CNT_W-1:0]            i_job_m,
    input  wire logic [CENTER_W-1:0]         i_job_center,
    input  wire logic [SLOTS*ATOM_BITS-1:0]  i_job_sel,
    output logic                             o_pop,
    bat_out_if.source                        o_result
);

    logic [LIMIT_W-1:0]   r_regular_limit;
    logic [LIMIT_W-1:0]   r_high_limit;
    logic [COUNT_W-1:0]   r_regular_cnt;
    logic [COUNT_W-1:0]   r_high_cnt;
    logic                 r_halted;

    logic                 r_busy;
    logic [ATOM_BITS-1:0] r_list  [SLOTS];  // head is the first end
    logic [ATOM_BITS-1:0] r_qlist [SLOTS];  // head is the second end
    logic [CNT_W-1:0]     r_pm;             // entries left in r_list
    logic [CNT_W-1:0]     r_qn;             // entries left in r_qlist
    logic                 r_high;
    logic                 r_is3;
    logic [CENTER_W-1:0]  r_center;
    logic [ATOM_BITS-1:0] r_trio [3];
    logic [1:0]           r_pair;

    logic                 r_out_valid;
    logic                 r_o_high;
    logic [15:0]          r_o_idx;
    logic [ATOM_BITS-1:0] r_o_first;
    logic [CENTER_W-1:0]  r_o_vertex;
    logic [ATOM_BITS-1:0] r_o_second;
    logic [ATOM_BITS-1:0] r_o_third;
    logic                 r_o_ovf;
    logic                 r_o_last;

    logic [ATOM_BITS-1:0] job_sel   [SLOTS];
    logic [ATOM_BITS-1:0] job_sh1   [SLOTS];
    logic [ATOM_BITS-1:0] list_sh1  [SLOTS];
    logic [ATOM_BITS-1:0] list_sh2  [SLOTS];
    logic [ATOM_BITS-1:0] qlist_sh1 [SLOTS];
    logic [ATOM_BITS-1:0] trio_in   [3];

    logic                 step;
    logic [COUNT_W-1:0]   idx;
    logic [COUNT_W-1:0]   cnt_inc;
    logic                 ovf;
    logic                 pair_done;
    logic                 atom_done;
    logic [ATOM_BITS-1:0] third;

    // Fixed-position shifted views of the lists
    for (genvar i = 0; i < SLOTS; i++) begin : g_shift
        assign job_sel[i] = i_job_sel[i*ATOM_BITS +: ATOM_BITS];
        if (i + 1 < SLOTS) begin : g_s1
            assign job_sh1[i]   = i_job_sel[(i+1)*ATOM_BITS +: ATOM_BITS];
            assign list_sh1[i]  = r_list[i+1];
            assign qlist_sh1[i] = r_qlist[i+1];
        end else begin : g_s1z
            assign job_sh1[i]   = '0;
            assign list_sh1[i]  = '0;
            assign qlist_sh1[i] = '0;
        end
        if (i + 2 < SLOTS) begin : g_s2
            assign list_sh2[i] = r_list[i+2];
        end else begin : g_s2z
            assign list_sh2[i] = '0;
        end
    end

    for (genvar j = 0; j < 3; j++) begin : g_trio
        if (j < SLOTS) begin : g_t
            assign trio_in[j] = i_job_sel[j*ATOM_BITS +: ATOM_BITS];
        end else begin : g_tz
            assign trio_in[j] = '0;
        end
    end

    assign o_pop = !r_busy && i_job_valid;
    assign step  = r_busy && (!r_out_valid || o_result.ready);

    assign idx     = r_high ? r_high_cnt : r_regular_cnt;
    assign cnt_inc = idx + COUNT_W'(1);
    assign ovf     = cnt_inc > {1'b0, (r_high ? r_high_limit : r_regular_limit)};

    assign pair_done = (r_qn == CNT_W'(1));
    assign atom_done = ovf || (pair_done && r_pm == CNT_W'(2));

    // Three-neighbor regular angle: pairs (0,1), (0,2), (1,2) leave 2, 1, 0
    always_comb begin
        case (r_pair)
            2'd0:    third = r_trio[2];
            2'd1:    third = r_trio[1];
            default: third = r_trio[0];
        endcase
        if (!r_is3) begin
            third = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regular_limit <= '1;
            r_high_limit    <= '1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_REGULAR_LIMIT: r_regular_limit <= i_cfg_data;
                CFG_HIGH_LIMIT:    r_high_limit    <= i_cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy        <= 1'b0;
            r_halted      <= 1'b0;
            r_regular_cnt <= '0;
            r_high_cnt    <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (o_pop) begin
                if (i_job_ctl.restart) begin
                    r_regular_cnt <= '0;
                    r_high_cnt    <= '0;
                    r_halted      <= 1'b0;
                end else if (!r_halted) begin
                    r_busy <= 1'b1;
                end
            end
            if (step) begin
                if (r_high) begin
                    r_high_cnt <= cnt_inc;
                end else begin
                    r_regular_cnt <= cnt_inc;
                end
                if (ovf) begin
                    r_halted <= 1'b1;
                end
                if (atom_done) begin
                    r_busy <= 1'b0;
                end
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_list[i]  <= job_sel[i];
                r_qlist[i] <= job_sh1[i];
            end
            r_pm     <= i_job_m;
            r_qn     <= i_job_m - CNT_W'(1);
            r_high   <= i_job_ctl.high;
            r_is3    <= !i_job_ctl.high && (32'(i_job_m) == 3);
            r_center <= i_job_center;
            r_pair   <= '0;
            for (int j = 0; j < 3; j++) begin
                r_trio[j] <= trio_in[j];
            end
        end else if (step) begin
            r_pair <= r_pair + 2'd1;
            if (pair_done) begin
                for (int i = 0; i < SLOTS; i++) begin
                    r_list[i]  <= list_sh1[i];
                    r_qlist[i] <= list_sh2[i];
                end
                r_pm <= r_pm - CNT_W'(1);
                r_qn <= r_pm - CNT_W'(2);
            end else begin
                for (int i = 0; i < SLOTS; i++) begin
                    r_qlist[i] <= qlist_sh1[i];
                end
                r_qn <= r_qn - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_o_high   <= r_high;
            r_o_idx    <= idx[15:0];
            r_o_first  <= r_list[0];
            r_o_vertex <= r_center;
            r_o_second <= r_qlist[0];
            r_o_third  <= third;
            r_o_ovf    <= ovf;
            r_o_last   <= atom_done;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.is_high_coord  = r_o_high;
    assign o_result.entry_index    = r_o_idx;
    assign o_result.first_end      = r_o_first;
    assign o_result.vertex         = r_o_vertex;
    assign o_result.second_end     = r_o_second;
    assign o_result.third_neighbor = r_o_third;
    assign o_result.overflow       = r_o_ovf;
    assign o_result.last_of_atom   = r_o_last;

endmodule

`default_nettype wire

>>> src/bond_angle_triple_generator.sv
// Bond angle triple generator.
// Item channel (i_item, valid/ready): one bond slot per item (cmd = slot), or a
// restart (cmd = restart) that clears the slot buffer, both entry counts and the
// halt flag. The slot flagged last_slot closes the atom and releases its angles.
// Result channel (o_result, valid/ready): one angle entry per item, in pair order,
// last_of_atom marking the final one of an atom (or the overflowing one).
// Config port: i_cfg_we/i_cfg_idx/i_cfg_data set regular_limit (0) and
// high_limit (1); write only while the block is idle.
// After the last slot the job sits in a two-entry queue; the back end loads it
// from the queue head, then emits one entry per cycle while the receiver is
// ready. An atom with m selected neighbors yields m*(m-1)/2 entries (up to 28
// with 8 slots); the back end takes the next job only after its last entry.
// The front keeps taking slots of following atoms while the back end works,
// until the queue holds two pending jobs.
// Receiver stall: the output register holds the entry; the back end stops and
// the queue fills, after which i_item.ready drops.
// Reset: counts zero, limits 65535, queue and output empty, not halted.
// After an overflow, atoms are dropped until a restart item passes the queue.
`default_nettype none

module bond_angle_triple_generator
    import bat_pkg::*;
#(
    parameter int SLOTS     = 8,
    parameter int ATOM_BITS = 10
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    bat_in_if.sink                    i_item,
    bat_out_if.source                 o_result,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [LIMIT_W-1:0]   i_cfg_data
);

    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int SEL_W   = SLOTS * ATOM_BITS;
    localparam int JOB_W   = $bits(t_job_ctl) + CNT_W + CENTER_W + SEL_W;
    localparam int Q_DEPTH = 2;

    // Front-end job
    logic                 push;
    t_job_ctl             f_ctl;
    logic [CNT_W-1:0]     f_m;
    logic [CENTER_W-1:0]  f_center;
    logic [SEL_W-1:0]     f_sel;

    // Queue head
    logic                 q_full;
    logic                 q_valid;
    logic                 pop;
    logic [JOB_W-1:0]     q_data;
    t_job_ctl             b_ctl;
    logic [CNT_W-1:0]     b_m;
    logic [CENTER_W-1:0]  b_center;
    logic [SEL_W-1:0]     b_sel;

    bat_front #(
        .SLOTS     (SLOTS),
        .ATOM_BITS (ATOM_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (i_item),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_job_ctl    (f_ctl),
        .o_job_m      (f_m),
        .o_job_center (f_center),
        .o_job_sel    (f_sel)
    );

    bat_queue #(
        .WIDTH (JOB_W),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_ctl, f_m, f_center, f_sel}),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    assign {b_ctl, b_m, b_center, b_sel} = q_data;

    bat_back #(
        .SLOTS     (SLOTS),
        .ATOM_BITS (ATOM_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_job_valid  (q_valid),
        .i_job_ctl    (b_ctl),
        .i_job_m      (b_m),
        .i_job_center (b_center),
        .i_job_sel    (b_sel),
        .o_pop        (pop),
        .o_result     (o_result)
    );

endmodule

`default_nettype wire
